>>> rtl/lbpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbpd_pkg;

  localparam int LINE_CELLS_DEF = 160;

  localparam int CELL_W     = 5;
  localparam int COLOR_W    = 8;
  localparam int PAL_DEPTH  = 32;
  localparam int PAL_AW     = 5;
  localparam int POS_W      = 8;
  localparam int PSEL_W     = 3;
  localparam int ADV_W      = 3;

  localparam int FUNC_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE_BYTE = 3'd0,
    FUNC_READ_PIXEL = 3'd1,
    FUNC_SWAP       = 3'd2,
    FUNC_CLEAR      = 3'd3,
    FUNC_PAL_WRITE  = 3'd4
  } func_e;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_OFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RENDER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_KILL  = 2'd2;

  localparam logic [1:0] RM_SPLIT = 2'd2;
  localparam logic [1:0] RM_PAIR  = 2'd3;

  localparam logic [ADV_W-1:0] ADV_WIDE   = 3'd2;
  localparam logic [ADV_W-1:0] ADV_NORMAL = 3'd4;

endpackage

`default_nettype wire

>>> rtl/line_buffer_palette_display_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-buffered scanline store with a 32-entry palette. After reset the block
// sweeps both line buffers to zero and accepts no item meanwhile. All cell
// state sits in one synchronous line memory with a single write port, so a
// write byte writes one cell at a time (two cells wide, four otherwise), a read
// pixel steps through line read, palette read and color register, a palette
// broadcast makes eight palette writes and a clear writes one cell per cycle.
// A finished result waits in the output register while the next item is taken;
// a result ready while the previous one is still held stalls the block until it
// drains.
module line_buffer_palette_display_core #(
  parameter int LINE_CELLS = lbpd_pkg::LINE_CELLS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [lbpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [lbpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // gfx_byte[7:0], hpos[15:8], palette_sel[18:16], wide_mode[19],
  // pixel_x[27:20], pal_index[32:28], pal_value[40:33], zero above
  input  wire [lbpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func[2:0]
  input  wire [lbpd_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // left_color[7:0], right_color[15:8], cells_advanced[18:16], zero above
  output logic [lbpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int DEPTH  = 2 * LINE_CELLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ALL  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_LINE = ADDR_W'(LINE_CELLS - 1);
  localparam logic [ADDR_W-1:0] BASE_HI   = ADDR_W'(LINE_CELLS);
  localparam logic [lbpd_pkg::POS_W:0] LIMIT = (lbpd_pkg::POS_W + 1)'(LINE_CELLS);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_WRITE, ST_CLEAR, ST_PAL,
    ST_RD_CELL, ST_RD_MAP, ST_RD_COL, ST_FIN
  } state_e;

  // configuration
  logic       transp_off_q;
  logic [1:0] render_mode_q;
  logic       color_kill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_off_q  <= 1'b0;
      render_mode_q <= 2'd0;
      color_kill_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbpd_pkg::REG_TRANSP_OFF:  transp_off_q  <= cfg_data_i[0];
        lbpd_pkg::REG_RENDER_MODE: render_mode_q <= cfg_data_i[1:0];
        lbpd_pkg::REG_COLOR_KILL:  color_kill_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e                             state_q;
  logic [ADDR_W-1:0]                  cnt_q;
  logic                               sel_q;
  logic [7:0]                         gfx_q;
  logic [lbpd_pkg::POS_W-1:0]         hpos_q;
  logic [lbpd_pkg::PSEL_W-1:0]        psel_q;
  logic                               wide_q;
  logic [lbpd_pkg::POS_W-1:0]         pix_q;
  logic [lbpd_pkg::PAL_AW-1:0]        pidx_q;
  logic [lbpd_pkg::COLOR_W-1:0]       pval_q;
  logic [lbpd_pkg::COLOR_W-1:0]       res_left_q, res_right_q;
  logic [lbpd_pkg::ADV_W-1:0]         res_adv_q;
  logic                               m_valid_q;
  logic [lbpd_pkg::COLOR_W-1:0]       m_left_q, m_right_q;
  logic [lbpd_pkg::ADV_W-1:0]         m_adv_q;

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // line memory ports
  logic                       lw_en;
  logic [ADDR_W-1:0]          lw_addr;
  logic [lbpd_pkg::CELL_W-1:0] lw_data;
  logic [ADDR_W-1:0]          lr_addr;
  logic [lbpd_pkg::CELL_W-1:0] lr_data_q;
  logic [lbpd_pkg::CELL_W-1:0] line_mem [DEPTH];

  logic [ADDR_W-1:0]           act_base, sby_base;
  logic [lbpd_pkg::POS_W-1:0]  wr_pos;
  logic                        wr_in_range;
  logic [1:0]                  pair;
  logic [lbpd_pkg::CELL_W-1:0] wr_cell;
  logic                        rd_oob;
  logic                        wr_last;

  assign act_base = sel_q ? BASE_HI : '0;
  assign sby_base = sel_q ? '0 : BASE_HI;
  assign wr_pos   = hpos_q + {6'd0, cnt_q[1:0]};
  assign wr_in_range = ({1'b0, wr_pos} < LIMIT);
  assign rd_oob   = ({1'b0, pix_q} >= LIMIT);
  assign wr_last  = wide_q ? cnt_q[0] : (cnt_q[1:0] == 2'd3);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pair = gfx_q[7:6];
      2'd1:    pair = gfx_q[5:4];
      2'd2:    pair = gfx_q[3:2];
      default: pair = gfx_q[1:0];
    endcase
    if (wide_q) begin
      // wide: palette bit 2 on top, then two bit pairs from separate nibbles
      wr_cell = cnt_q[0] ? {psel_q[2], gfx_q[1:0], gfx_q[5:4]}
                         : {psel_q[2], gfx_q[3:2], gfx_q[7:6]};
    end else begin
      wr_cell = {psel_q, pair};
    end
  end

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cnt_q;
    lw_data = '0;
    case (state_q)
      ST_INIT: lw_en = 1'b1;
      ST_WRITE: begin
        lw_en   = wr_in_range && ((wr_cell[1:0] != 2'd0) || transp_off_q);
        lw_addr = act_base + ADDR_W'(wr_pos);
        lw_data = wr_cell;
      end
      ST_CLEAR: begin
        lw_en   = 1'b1;
        lw_addr = act_base + cnt_q;
      end
      default: ;
    endcase
  end

  assign lr_addr = rd_oob ? '0 : (sby_base + ADDR_W'(pix_q));

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      line_mem[lw_addr] <= lw_data;
    end
    lr_data_q <= line_mem[lr_addr];
  end

  // palette memory: one write port, two read ports, valid bit per entry
  logic                          pw_en;
  logic [lbpd_pkg::PAL_AW-1:0]   pw_addr;
  logic [lbpd_pkg::PAL_AW-1:0]   pl_addr, pr_addr;
  logic [lbpd_pkg::COLOR_W-1:0]  pal_mem [lbpd_pkg::PAL_DEPTH];
  logic [lbpd_pkg::PAL_DEPTH-1:0] pal_vld_q;
  logic [lbpd_pkg::COLOR_W-1:0]  pl_data_q, pr_data_q;
  logic                          pl_vld_q, pr_vld_q;
  logic                          pal_bcast;
  logic [lbpd_pkg::CELL_W-1:0]   rd_cell;

  assign pal_bcast = (pidx_q == '0);
  assign pw_en     = (state_q == ST_PAL) && (pal_bcast || (pidx_q[1:0] != 2'd0));
  assign pw_addr   = pal_bcast ? {cnt_q[2:0], 2'b00} : pidx_q;
  assign rd_cell   = rd_oob ? '0 : lr_data_q;

  always_comb begin
    case (render_mode_q)
      lbpd_pkg::RM_SPLIT: begin
        pl_addr = {rd_cell[4], 2'b00, rd_cell[1], rd_cell[3]};
        pr_addr = {rd_cell[4], 2'b00, rd_cell[0], rd_cell[2]};
      end
      lbpd_pkg::RM_PAIR: begin
        pl_addr = {rd_cell[4:2], rd_cell[1], 1'b0};
        pr_addr = {rd_cell[4:2], rd_cell[0], 1'b0};
      end
      default: begin
        pl_addr = rd_cell;
        pr_addr = rd_cell;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      pal_mem[pw_addr] <= pval_q;
    end
    pl_data_q <= pal_mem[pl_addr];
    pr_data_q <= pal_mem[pr_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      pl_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
    end else begin
      if (pw_en) begin
        pal_vld_q[pw_addr] <= 1'b1;
      end
      pl_vld_q <= pal_vld_q[pl_addr];
      pr_vld_q <= pal_vld_q[pr_addr];
    end
  end

  logic [lbpd_pkg::COLOR_W-1:0] col_l, col_r;
  assign col_l = pl_vld_q ? pl_data_q : '0;
  assign col_r = pr_vld_q ? pr_data_q : '0;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      gfx_q       <= '0;
      hpos_q      <= '0;
      psel_q      <= '0;
      wide_q      <= 1'b0;
      pix_q       <= '0;
      pidx_q      <= '0;
      pval_q      <= '0;
      res_left_q  <= '0;
      res_right_q <= '0;
      res_adv_q   <= '0;
      m_valid_q   <= 1'b0;
      m_left_q    <= '0;
      m_right_q   <= '0;
      m_adv_q     <= '0;
    end else begin
      // the finish step reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (cnt_q == LAST_ALL) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            gfx_q       <= s_axis_tdata[7:0];
            hpos_q      <= s_axis_tdata[15:8];
            psel_q      <= s_axis_tdata[18:16];
            wide_q      <= s_axis_tdata[19];
            pix_q       <= s_axis_tdata[27:20];
            pidx_q      <= s_axis_tdata[32:28];
            pval_q      <= s_axis_tdata[40:33];
            cnt_q       <= '0;
            res_left_q  <= '0;
            res_right_q <= '0;
            res_adv_q   <= (lbpd_pkg::func_e'(s_axis_tuser) == lbpd_pkg::FUNC_WRITE_BYTE) ?
                           (s_axis_tdata[19] ? lbpd_pkg::ADV_WIDE : lbpd_pkg::ADV_NORMAL) :
                           '0;
            case (lbpd_pkg::func_e'(s_axis_tuser))
              lbpd_pkg::FUNC_WRITE_BYTE: state_q <= ST_WRITE;
              lbpd_pkg::FUNC_READ_PIXEL: state_q <= ST_RD_CELL;
              lbpd_pkg::FUNC_SWAP: begin
                sel_q   <= ~sel_q;
                state_q <= ST_FIN;
              end
              lbpd_pkg::FUNC_CLEAR:     state_q <= ST_CLEAR;
              lbpd_pkg::FUNC_PAL_WRITE: state_q <= ST_PAL;
              default:                  state_q <= ST_FIN;
            endcase
          end
        end
        ST_WRITE: begin
          cnt_q <= cnt_q + 1'b1;
          if (wr_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_LINE) begin
            state_q <= ST_FIN;
          end
        end
        ST_PAL: begin
          cnt_q <= cnt_q + 1'b1;
          if (!pal_bcast || (cnt_q[2:0] == 3'd7)) begin
            state_q <= ST_FIN;
          end
        end
        ST_RD_CELL: state_q <= ST_RD_MAP;
        ST_RD_MAP:  state_q <= ST_RD_COL;
        ST_RD_COL: begin
          res_left_q  <= color_kill_q ? {4'd0, col_l[3:0]} : col_l;
          res_right_q <= color_kill_q ? {4'd0, col_r[3:0]} : col_r;
          state_q     <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_left_q  <= res_left_q;
            m_right_q <= res_right_q;
            m_adv_q   <= res_adv_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_adv_q, m_right_q, m_left_q};

`ifndef NO_ASSERTIONS
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !s_axis_tready)
    else $error("item accepted during line store init sweep");

  a_line_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_en |-> (lw_addr <= LAST_ALL))
    else $error("line store write beyond depth");

  a_bcast_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pw_en && pal_bcast) |-> (pw_addr[1:0] == 2'd0))
    else $error("palette broadcast hit an unaligned entry");

  a_adv_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_adv_q != '0)) |-> ((m_left_q == '0) && (m_right_q == '0)))
    else $error("write byte result carries colors");

  a_result_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside finish step");
`endif

endmodule

`default_nettype wire

>>> tb/sv/line_buffer_palette_display_core_tb.sv
`timescale 1ns / 1ps

module line_buffer_palette_display_core_tb;

  localparam int LINE_CELLS = lbpd_pkg::LINE_CELLS_DEF;
  // must outlast the reset sweep, a clear and the pressure hold
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct packed {
    logic [lbpd_pkg::FUNC_W-1:0]  func;
    logic [7:0]                   gfx;
    logic [lbpd_pkg::POS_W-1:0]   hpos;
    logic [lbpd_pkg::PSEL_W-1:0]  psel;
    logic                         wide;
    logic [lbpd_pkg::POS_W-1:0]   px;
    logic [lbpd_pkg::PAL_AW-1:0]  pidx;
    logic [lbpd_pkg::COLOR_W-1:0] pval;
  } item_t;

  typedef struct packed {
    logic [lbpd_pkg::COLOR_W-1:0] left_color;
    logic [lbpd_pkg::COLOR_W-1:0] right_color;
    logic [lbpd_pkg::ADV_W-1:0]   adv;
  } pixel_out_t;

  class line_palette_tracker;
    logic [lbpd_pkg::CELL_W-1:0]  cells [2][LINE_CELLS];
    logic [lbpd_pkg::COLOR_W-1:0] pal [lbpd_pkg::PAL_DEPTH];
    bit                           act;
    bit                           transp_off;
    logic [1:0]                   rmode;
    bit                           ckill;
    pixel_out_t                   pending_outs [$];
    int                           errors;
    int                           n_checked;

    function new();
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < LINE_CELLS; i++) cells[b][i] = '0;
      for (int i = 0; i < lbpd_pkg::PAL_DEPTH; i++) pal[i] = '0;
      act = 0;
      transp_off = 0;
      rmode = '0;
      ckill = 0;
      errors = 0;
      n_checked = 0;
    endfunction

    function int outstanding();
      return pending_outs.size();
    endfunction

    function void set_reg(logic [lbpd_pkg::CFG_IDX_W-1:0] idx,
                          logic [lbpd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        lbpd_pkg::REG_TRANSP_OFF:  transp_off = val[0];
        lbpd_pkg::REG_RENDER_MODE: rmode = val[1:0];
        lbpd_pkg::REG_COLOR_KILL:  ckill = val[0];
        default: ;
      endcase
    endfunction

    function void store_cell(logic [lbpd_pkg::POS_W-1:0] pos,
                             logic [lbpd_pkg::CELL_W-1:0] cval);
      if (int'(pos) < LINE_CELLS && (cval[1:0] != 2'b00 || transp_off))
        cells[act][pos] = cval;
    endfunction

    function logic [lbpd_pkg::COLOR_W-1:0] shade(logic [lbpd_pkg::PAL_AW-1:0] idx);
      logic [lbpd_pkg::COLOR_W-1:0] v;
      v = pal[idx];
      if (ckill) v = v & 8'h0f;
      return v;
    endfunction

    function void note_item(item_t it);
      pixel_out_t                  res;
      logic [lbpd_pkg::POS_W-1:0]  pos;
      logic [lbpd_pkg::CELL_W-1:0] c;
      logic [lbpd_pkg::PAL_AW-1:0] li, ri;
      res = '0;
      pos = it.hpos;
      case (it.func)
        lbpd_pkg::FUNC_WRITE_BYTE: begin
          if (it.wide) begin
            store_cell(pos, {it.psel[2], it.gfx[3:2], it.gfx[7:6]});
            pos = pos + 1'b1;
            store_cell(pos, {it.psel[2], it.gfx[1:0], it.gfx[5:4]});
            res.adv = lbpd_pkg::ADV_WIDE;
          end else begin
            for (int i = 0; i < 4; i++) begin
              store_cell(pos, {it.psel, it.gfx[7-2*i -: 2]});
              pos = pos + 1'b1;
            end
            res.adv = lbpd_pkg::ADV_NORMAL;
          end
        end
        lbpd_pkg::FUNC_READ_PIXEL: begin
          c = (int'(it.px) < LINE_CELLS) ? cells[!act][it.px] : '0;
          case (rmode)
            lbpd_pkg::RM_SPLIT: begin
              li = {c[4], 2'b00, c[1], c[3]};
              ri = {c[4], 2'b00, c[0], c[2]};
            end
            lbpd_pkg::RM_PAIR: begin
              li = {c[4:2], c[1], 1'b0};
              ri = {c[4:2], c[0], 1'b0};
            end
            default: begin
              li = c;
              ri = c;
            end
          endcase
          res.left_color = shade(li);
          res.right_color = shade(ri);
        end
        lbpd_pkg::FUNC_SWAP: act = !act;
        lbpd_pkg::FUNC_CLEAR: for (int i = 0; i < LINE_CELLS; i++) cells[act][i] = '0;
        lbpd_pkg::FUNC_PAL_WRITE: begin
          if (it.pidx[1:0] != 2'b00) pal[it.pidx] = it.pval;
          else if (it.pidx == '0)
            for (int i = 0; i < lbpd_pkg::PAL_DEPTH; i += 4) pal[i] = it.pval;
        end
        default: ;
      endcase
      pending_outs.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH result %0d: %s", n_checked, msg);
    endtask

    task check_result(logic [lbpd_pkg::OUT_DATA_W-1:0] d);
      pixel_out_t exp_out;
      if (pending_outs.size() == 0) begin
        report($sformatf("unexpected result %h", d));
      end else begin
        exp_out = pending_outs.pop_front();
        if (d[7:0] !== exp_out.left_color)
          report($sformatf("left_color %h, want %h", d[7:0], exp_out.left_color));
        if (d[15:8] !== exp_out.right_color)
          report($sformatf("right_color %h, want %h", d[15:8], exp_out.right_color));
        if (d[18:16] !== exp_out.adv)
          report($sformatf("cells_advanced %0d, want %0d", d[18:16], exp_out.adv));
      end
      n_checked++;
    endtask
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [lbpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [lbpd_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [lbpd_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [lbpd_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [lbpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

  line_palette_tracker tracker = new();
  bit no_idle = 0;
  bit hold_req = 0;

  line_buffer_palette_display_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t rand_item(logic [lbpd_pkg::FUNC_W-1:0] f);
    item_t it;
    it.func = f;
    it.gfx = 8'($urandom_range(0, 255));
    it.hpos = 8'($urandom_range(0, 255));
    it.psel = 3'($urandom_range(0, 7));
    it.wide = 1'($urandom_range(0, 1));
    it.px = 8'($urandom_range(0, 255));
    it.pidx = 5'($urandom_range(0, 31));
    it.pval = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t mk_write(logic [7:0] g, logic [7:0] h, logic [2:0] p, logic w);
    item_t it;
    it = '0;
    it.func = lbpd_pkg::FUNC_WRITE_BYTE;
    it.gfx = g;
    it.hpos = h;
    it.psel = p;
    it.wide = w;
    return it;
  endfunction

  function automatic item_t mk_read(logic [7:0] x);
    item_t it;
    it = '0;
    it.func = lbpd_pkg::FUNC_READ_PIXEL;
    it.px = x;
    return it;
  endfunction

  function automatic item_t mk_pal(logic [4:0] idx, logic [7:0] v);
    item_t it;
    it = '0;
    it.func = lbpd_pkg::FUNC_PAL_WRITE;
    it.pidx = idx;
    it.pval = v;
    return it;
  endfunction

  function automatic item_t mk_op(logic [lbpd_pkg::FUNC_W-1:0] f);
    item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  task automatic send_item(item_t it);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {7'd0, it.pval, it.pidx, it.px, it.wide, it.psel, it.hpos, it.gfx};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(it);
    g = no_idle ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [lbpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [lbpd_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic t, logic [1:0] rm, logic ck);
    cfg_write(lbpd_pkg::REG_TRANSP_OFF, {1'b0, t});
    cfg_write(lbpd_pkg::REG_RENDER_MODE, rm);
    cfg_write(lbpd_pkg::REG_COLOR_KILL, {1'b0, ck});
    cfg_we_i <= 1'b0;
  endtask

  // drain everything so the block is idle before touching the registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // one pass: optional clear, bytes into the active line, swap, read back
  task automatic run_phase(int n_items);
    int sent, nw, nr, r;
    logic [7:0] pos, start;
    item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(mk_op(lbpd_pkg::FUNC_CLEAR));
        sent++;
      end
      start = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 159))
                                            : 8'($urandom_range(0, 255));
      pos = start;
      nw = $urandom_range(4, 20);
      for (int i = 0; i < nw; i++) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          it = rand_item(lbpd_pkg::FUNC_WRITE_BYTE);
          it.hpos = pos;
          pos = pos + (it.wide ? 8'd2 : 8'd4);
          sent++;
        end else if (r < 88) begin
          it = rand_item(lbpd_pkg::FUNC_PAL_WRITE);
          if ($urandom_range(0, 9) == 0) it.pidx = '0;
          sent++;
        end else if (r < 93) begin
          it = rand_item(3'($urandom_range(5, 7)));
        end else begin
          it = rand_item(lbpd_pkg::FUNC_READ_PIXEL);
          sent++;
        end
        send_item(it);
      end
      send_item(rand_item(lbpd_pkg::FUNC_SWAP));
      sent++;
      nr = $urandom_range(4, 20);
      for (int i = 0; i < nr; i++) begin
        it = rand_item(lbpd_pkg::FUNC_READ_PIXEL);
        r = $urandom_range(0, 9);
        if (r < 5) it.px = start + 8'($urandom_range(0, 40));
        else if (r < 9) it.px = 8'($urandom_range(0, LINE_CELLS - 1));
        send_item(it);
        sent++;
      end
    end
  endtask

  // receiver
  initial begin
    int run, g;
    @(posedge clk_i);
    forever begin
      run = no_idle ? 40 : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else begin
        g = no_idle ? 0 : gap_len();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("TIMEOUT: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [3:0] settings [6];
    settings[0] = {1'b1, 2'd1, 1'b0};
    settings[1] = {1'b0, 2'd2, 1'b1};
    settings[2] = {1'b1, 2'd3, 1'b1};
    settings[3] = {1'b0, 2'd3, 1'b0};
    settings[4] = {1'b1, 2'd2, 1'b0};
    settings[5] = {1'b0, 2'd0, 1'b1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_settings(1'b0, 2'd0, 1'b0);

    send_item(mk_pal(5'd0, 8'hff));        // broadcast to every fourth entry
    send_item(mk_pal(5'd4, 8'h12));        // other multiple of four: ignored
    send_item(mk_pal(5'd31, 8'h5a));
    send_item(mk_pal(5'd1, 8'ha5));
    send_item(mk_pal(5'd19, 8'h00));
    send_item(mk_pal(5'd14, 8'h3c));
    send_item(mk_write(8'hff, 8'd0, 3'd7, 1'b0));
    send_item(mk_write(8'h00, 8'd4, 3'd0, 1'b0));   // all transparent
    send_item(mk_write(8'he4, 8'd158, 3'd5, 1'b0)); // last two fall off the line
    send_item(mk_write(8'h1b, 8'd255, 3'd3, 1'b0)); // position wraps
    send_item(mk_write(8'hc9, 8'd10, 3'd4, 1'b1));
    send_item(mk_write(8'h00, 8'd159, 3'd7, 1'b1));
    send_item(mk_op(3'd5));
    send_item(rand_item(3'd7));
    send_item(mk_op(lbpd_pkg::FUNC_SWAP));
    send_item(mk_read(8'd0));
    send_item(mk_read(8'd2));
    send_item(mk_read(8'd10));
    send_item(mk_read(8'd159));
    send_item(mk_read(8'd160));            // beyond the line
    send_item(mk_read(8'd255));
    send_item(mk_op(lbpd_pkg::FUNC_CLEAR));
    send_item(mk_op(lbpd_pkg::FUNC_SWAP));
    send_item(mk_read(8'd1));
    send_item(mk_op(lbpd_pkg::FUNC_SWAP));
    settle();

    for (int p = 0; p < 6; p++) begin
      apply_settings(settings[p][3], settings[p][2:1], settings[p][0]);
      if (p == 1) begin
        hold_req = 1;
        no_idle = 1;
        run_phase(40);
        no_idle = 0;
        run_phase(ITEMS_PER_PHASE - 40);
      end else begin
        no_idle = (p == 3);
        run_phase(ITEMS_PER_PHASE);
        no_idle = 0;
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> line_buffer_palette_display_core.f
rtl/lbpd_pkg.sv
rtl/line_buffer_palette_display_core.sv
tb/sv/line_buffer_palette_display_core_tb.sv
